// File: rtl/wojs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the windowed offset jitter statistics block
package wojs_pkg;

    localparam int OFFSET_BITS = 40;
    localparam int FRAC_BITS   = 16;
    localparam int MEAN_W      = OFFSET_BITS + FRAC_BITS;
    localparam int DIFF_W      = MEAN_W + 1;
    localparam int CMEAN_W     = 57;
    localparam int CDIFF_W     = CMEAN_W + 1;
    localparam int COMP_W      = 41;
    localparam int CNT_W       = 16;
    localparam int TOT_W       = 48;
    localparam int M2_W        = 64;
    localparam int DIVN_W      = 66;
    localparam int DIVD_W      = 48;
    localparam int MUL_W       = 64;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RAD_W       = 84;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int OUT_W       = 40;

    localparam logic [CNT_W-1:0] WIN_RESET = 16'd1000;
    localparam logic [CNT_W-1:0] MIN_WIN   = 16'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MDIV,
        ST_MWAIT,
        ST_MUL1,
        ST_M1WAIT,
        ST_COMP,
        ST_CDIV,
        ST_CWAIT,
        ST_CHECK,
        ST_VDIV,
        ST_VWAIT,
        ST_MUL2,
        ST_M2WAIT,
        ST_SQ1,
        ST_SQ1WAIT,
        ST_SQ2,
        ST_SQ2WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_COMP,
        DIV_VAR
    } div_sel_t;

    typedef enum logic {
        MUL_DELTA,
        MUL_MEAN
    } mul_sel_t;

    typedef enum logic {
        SQ_VAR,
        SQ_RMS
    } sqrt_sel_t;

    typedef struct packed {
        logic      load;
        logic      div_start;
        div_sel_t  div_sel;
        logic      upd_mean;
        logic      mul_start;
        mul_sel_t  mul_sel;
        logic      upd_m2;
        logic      upd_comp;
        logic      upd_comp_mean;
        logic      save_var;
        logic      save_msq;
        logic      sqrt_start;
        sqrt_sel_t sqrt_sel;
        logic      save_std;
        logic      save_rms;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic sqrt_done;
        logic opposite;
        logic win_close;
        logic out_free;
    } status_t;

endpackage

// File: rtl/wojs_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample input, result output and configuration
interface wojs_in_if;
    import wojs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] offset_ns;
    modport source (output valid, output offset_ns, input ready);
    modport sink (input valid, input offset_ns, output ready);
endinterface

interface wojs_out_if;
    import wojs_pkg::*;
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] comp_offset_ns;
    logic [COMP_W-1:0] comp_mean_ns;
    logic [TOT_W-1:0]  total_samples;
    logic              window_done;
    logic [OUT_W-1:0]  win_mean_ns;
    logic [OUT_W-1:0]  win_stddev_ns;
    logic [OUT_W-1:0]  win_rms_ns;
    logic [OUT_W-1:0]  win_max_abs_ns;
    modport source (output valid, output comp_offset_ns, output comp_mean_ns,
                    output total_samples, output window_done, output win_mean_ns,
                    output win_stddev_ns, output win_rms_ns, output win_max_abs_ns,
                    input ready);
    modport sink (input valid, input comp_offset_ns, input comp_mean_ns,
                  input total_samples, input window_done, input win_mean_ns,
                  input win_stddev_ns, input win_rms_ns, input win_max_abs_ns,
                  output ready);
endinterface

interface wojs_cfg_if;
    import wojs_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] window_samples;
    modport source (output valid, output window_samples, input ready);
    modport sink (input valid, input window_samples, output ready);
endinterface

// File: rtl/wojs_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module wojs_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wojs_pkg::DIVN_W-1:0]  dividend,
    input  logic [wojs_pkg::DIVD_W-1:0]  divisor,
    output logic                         done,
    output logic [wojs_pkg::DIVN_W-1:0]  quotient
);
    import wojs_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [6:0]          cnt_reg;
    logic [DIVN_W-1:0]   quo_reg;
    logic [DIVD_W-1:0]   rem_reg;
    logic [DIVD_W-1:0]   dsr_reg;
    logic [DIVD_W:0]     rem_sh;
    logic [DIVD_W:0]     rem_sub;
    logic                ge;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIVN_W-1]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'(DIVN_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVN_W-2:0], ge};
            rem_reg <= rem_sub[DIVD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/wojs_mul.sv
`timescale 1ns / 1ps
// 64 x 64 multiplier built from four 32 x 32 partial products, accumulated in turn
module wojs_mul
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wojs_pkg::MUL_W-1:0]   a,
    input  logic [wojs_pkg::MUL_W-1:0]   b,
    output logic                         done,
    output logic [wojs_pkg::PROD_W-1:0]  product
);
    import wojs_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [1:0]          cnt_reg;
    logic [MUL_W-1:0]    a_reg;
    logic [MUL_W-1:0]    b_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [31:0]         ai;
    logic [31:0]         bi;
    logic [63:0]         pp;
    logic [PROD_W-1:0]   pp_sh;

    always_comb
    begin
        ai = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        bi = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = {32'b0, ai} * {32'b0, bi};
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            2'd2:    pp_sh = {pp, 64'b0};
            default: pp_sh = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: rtl/wojs_sqrt.sv
`timescale 1ns / 1ps
// digit-by-digit integer square root, one root bit per cycle
module wojs_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wojs_pkg::RAD_W-1:0]   radicand,
    output logic                         done,
    output logic [wojs_pkg::ROOT_W-1:0]  root
);
    import wojs_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [5:0]          cnt_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                ge;

    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(ROOT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/wojs_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for one sample through the shared arithmetic units
module wojs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wojs_pkg::status_t sts,
    output wojs_pkg::cmd_t    cmd
);
    import wojs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                state_next    = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.upd_mean = 1'b1;
                    state_next   = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (sts.opposite)
                begin
                    state_next = ST_COMP;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_DELTA;
                    state_next    = ST_M1WAIT;
                end
            end
            ST_M1WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.upd_m2 = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                cmd.upd_comp = 1'b1;
                state_next   = ST_CDIV;
            end
            ST_CDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_COMP;
                state_next    = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.upd_comp_mean = 1'b1;
                    state_next        = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.win_close ? ST_VDIV : ST_DONE;
            end
            ST_VDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VAR;
                state_next    = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.save_var = 1'b1;
                    state_next   = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_MEAN;
                state_next    = ST_M2WAIT;
            end
            ST_M2WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.save_msq = 1'b1;
                    state_next   = ST_SQ1;
                end
            end
            ST_SQ1:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_sel   = SQ_VAR;
                state_next     = ST_SQ1WAIT;
            end
            ST_SQ1WAIT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.save_std = 1'b1;
                    state_next   = ST_SQ2;
                end
            end
            ST_SQ2:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_sel   = SQ_RMS;
                state_next     = ST_SQ2WAIT;
            end
            ST_SQ2WAIT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.save_rms = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/wojs_dp.sv
`timescale 1ns / 1ps
// datapath: window and cumulative state, shared divider, multiplier and square root
module wojs_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wojs_pkg::cmd_t                cmd,
    output wojs_pkg::status_t             sts,
    input  logic [wojs_pkg::OFFSET_BITS-1:0] in_offset,
    input  logic                          cfg_we,
    input  logic [wojs_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [wojs_pkg::COMP_W-1:0]   out_comp,
    output logic [wojs_pkg::COMP_W-1:0]   out_comp_mean,
    output logic [wojs_pkg::TOT_W-1:0]    out_total,
    output logic                          out_done,
    output logic [wojs_pkg::OUT_W-1:0]    out_mean,
    output logic [wojs_pkg::OUT_W-1:0]    out_std,
    output logic [wojs_pkg::OUT_W-1:0]    out_rms,
    output logic [wojs_pkg::OUT_W-1:0]    out_peak
);
    import wojs_pkg::*;

    // state
    logic [CNT_W-1:0]       win_samples_reg;
    logic [CNT_W-1:0]       win_count_reg;
    logic [MEAN_W-1:0]      mean_reg;
    logic [M2_W-1:0]        m2_reg;
    logic [OFFSET_BITS-1:0] peak_reg;
    logic [TOT_W-1:0]       comp_count_reg;
    logic [CMEAN_W-1:0]     comp_mean_reg;

    // per sample working registers
    logic [OFFSET_BITS-1:0] x_reg;
    logic [DIFF_W-1:0]      d_reg;
    logic [COMP_W-1:0]      comp_reg;
    logic [CDIFF_W-1:0]     cd_reg;
    logic [DIVN_W-1:0]      var4_reg;
    logic [RAD_W-1:0]       rad_rms_reg;
    logic [OUT_W-1:0]       std_reg;
    logic [OUT_W-1:0]       rms_reg;

    // output register
    logic                   out_valid_reg;
    logic [COMP_W-1:0]      out_comp_reg;
    logic [COMP_W-1:0]      out_comp_mean_reg;
    logic [TOT_W-1:0]       out_total_reg;
    logic                   out_done_reg;
    logic [OUT_W-1:0]       out_mean_reg;
    logic [OUT_W-1:0]       out_std_reg;
    logic [OUT_W-1:0]       out_rms_reg;
    logic [OUT_W-1:0]       out_peak_reg;

    // combinational
    logic [MEAN_W-1:0]      in_fx;
    logic [MEAN_W-1:0]      x_fx;
    logic [DIFF_W-1:0]      d_in;
    logic [DIFF_W-1:0]      d2;
    logic [DIFF_W-1:0]      d_mag;
    logic [DIFF_W-1:0]      d2_mag;
    logic                   d_pos;
    logic                   d2_pos;
    logic [MEAN_W-1:0]      mean_mag;
    logic [MEAN_W:0]        mean_rsum;
    logic [COMP_W-1:0]      mean_ns;
    logic [OFFSET_BITS-1:0] x_mag;
    logic [COMP_W-1:0]      comp_val;
    logic [CMEAN_W-1:0]     comp_fx;
    logic [CDIFF_W-1:0]     cd_val;
    logic [CDIFF_W-1:0]     cd_mag;
    logic [CMEAN_W-1:0]     cm_mag;
    logic [CMEAN_W:0]       cm_rsum;
    logic [COMP_W:0]        cm_r;
    logic [COMP_W-1:0]      comp_mean_ns;
    logic [CNT_W-1:0]       eff_win;
    logic [PROD_W-1:0]      m2_sum;
    logic [M2_W-1:0]        m2_inc;

    logic                   div_done;
    logic [DIVN_W-1:0]      div_n;
    logic [DIVD_W-1:0]      div_d;
    logic [DIVN_W-1:0]      div_q;
    logic                   mul_done;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic                   sqrt_done;
    logic [RAD_W-1:0]       sqrt_rad;
    logic [ROOT_W-1:0]      sqrt_root;
    logic [ROOT_W-1:0]      root_half;
    logic [OUT_W-1:0]       root_sat;

    always_comb
    begin
        in_fx    = {in_offset, {FRAC_BITS{1'b0}}};
        x_fx     = {x_reg, {FRAC_BITS{1'b0}}};
        d_in     = {in_fx[MEAN_W-1], in_fx} - {mean_reg[MEAN_W-1], mean_reg};
        d2       = {x_fx[MEAN_W-1], x_fx} - {mean_reg[MEAN_W-1], mean_reg};
        d_mag    = d_reg[DIFF_W-1] ? (~d_reg + 1'b1) : d_reg;
        d2_mag   = d2[DIFF_W-1] ? (~d2 + 1'b1) : d2;
        d_pos    = !d_reg[DIFF_W-1] && (|d_reg);
        d2_pos   = !d2[DIFF_W-1] && (|d2);

        // mean rounded to whole ns, half away from zero
        mean_mag  = mean_reg[MEAN_W-1] ? (~mean_reg + 1'b1) : mean_reg;
        mean_rsum = {1'b0, mean_mag} + (MEAN_W + 1)'(1 << (FRAC_BITS - 1));
        mean_ns   = mean_reg[MEAN_W-1] ? (~mean_rsum[MEAN_W:FRAC_BITS] + 1'b1)
                                       : mean_rsum[MEAN_W:FRAC_BITS];

        x_mag    = x_reg[OFFSET_BITS-1] ? (~x_reg + 1'b1) : x_reg;
        comp_val = {x_reg[OFFSET_BITS-1], x_reg} - mean_ns;
        comp_fx  = {comp_reg, {FRAC_BITS{1'b0}}};
        cd_val   = {comp_fx[CMEAN_W-1], comp_fx} - {comp_mean_reg[CMEAN_W-1], comp_mean_reg};
        cd_mag   = cd_val[CDIFF_W-1] ? (~cd_val + 1'b1) : cd_val;

        cm_mag       = comp_mean_reg[CMEAN_W-1] ? (~comp_mean_reg + 1'b1) : comp_mean_reg;
        cm_rsum      = {1'b0, cm_mag} + (CMEAN_W + 1)'(1 << (FRAC_BITS - 1));
        cm_r         = comp_mean_reg[CMEAN_W-1] ? (~cm_rsum[CMEAN_W:FRAC_BITS] + 1'b1)
                                                : cm_rsum[CMEAN_W:FRAC_BITS];
        comp_mean_ns = cm_r[COMP_W-1:0];

        eff_win = (win_samples_reg < MIN_WIN) ? MIN_WIN : win_samples_reg;

        m2_sum = mul_p + PROD_W'(64'd1 << (2 * FRAC_BITS - 1));
        m2_inc = m2_sum[M2_W+2*FRAC_BITS-1:2*FRAC_BITS];

        root_half = (sqrt_root >> 1) + ROOT_W'(sqrt_root[0]);
        root_sat  = (|root_half[ROOT_W-1:OUT_W]) ? {OUT_W{1'b1}} : root_half[OUT_W-1:0];
    end

    // operand selection for the shared units
    always_comb
    begin
        case (cmd.div_sel)
            DIV_MEAN:
            begin
                div_n = DIVN_W'(d_mag) + DIVN_W'(win_count_reg >> 1);
                div_d = DIVD_W'(win_count_reg);
            end
            DIV_COMP:
            begin
                div_n = DIVN_W'(cd_mag) + DIVN_W'(comp_count_reg >> 1);
                div_d = comp_count_reg;
            end
            DIV_VAR:
            begin
                div_n = {m2_reg, 2'b00};
                div_d = DIVD_W'(win_count_reg - 1'b1);
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
            end
        endcase
        case (cmd.mul_sel)
            MUL_DELTA:
            begin
                mul_a = MUL_W'(d_mag);
                mul_b = MUL_W'(d2_mag);
            end
            MUL_MEAN:
            begin
                mul_a = MUL_W'(mean_mag);
                mul_b = MUL_W'(mean_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        case (cmd.sqrt_sel)
            SQ_VAR:  sqrt_rad = RAD_W'(var4_reg);
            SQ_RMS:  sqrt_rad = rad_rms_reg;
            default: sqrt_rad = '0;
        endcase
    end

    wojs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    wojs_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    wojs_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // window and cumulative state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_samples_reg <= WIN_RESET;
            win_count_reg   <= '0;
            mean_reg        <= '0;
            m2_reg          <= '0;
            peak_reg        <= '0;
            comp_count_reg  <= '0;
            comp_mean_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_samples_reg <= cfg_data;
            end
            if (cmd.load && (win_count_reg != {CNT_W{1'b1}}))
            begin
                win_count_reg <= win_count_reg + 1'b1;
            end
            if (cmd.upd_mean)
            begin
                mean_reg <= d_reg[DIFF_W-1] ? (mean_reg - div_q[MEAN_W-1:0])
                                            : (mean_reg + div_q[MEAN_W-1:0]);
            end
            if (cmd.upd_m2)
            begin
                if ((|m2_sum[PROD_W-1:M2_W+2*FRAC_BITS]) || (m2_inc > ~m2_reg))
                begin
                    m2_reg <= {M2_W{1'b1}};
                end
                else
                begin
                    m2_reg <= m2_reg + m2_inc;
                end
            end
            if (cmd.upd_comp)
            begin
                if (x_mag > peak_reg)
                begin
                    peak_reg <= x_mag;
                end
                if (comp_count_reg != {TOT_W{1'b1}})
                begin
                    comp_count_reg <= comp_count_reg + 1'b1;
                end
            end
            if (cmd.upd_comp_mean)
            begin
                comp_mean_reg <= cd_reg[CDIFF_W-1] ? (comp_mean_reg - div_q[CMEAN_W-1:0])
                                                   : (comp_mean_reg + div_q[CMEAN_W-1:0]);
            end
            // window closes: clear window state
            if (cmd.out_load && sts.win_close)
            begin
                win_count_reg <= '0;
                mean_reg      <= '0;
                m2_reg        <= '0;
                peak_reg      <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= in_offset;
            d_reg <= d_in;
        end
        if (cmd.upd_comp)
        begin
            comp_reg <= comp_val;
        end
        if (cmd.div_start && (cmd.div_sel == DIV_COMP))
        begin
            cd_reg <= cd_val;
        end
        if (cmd.save_var)
        begin
            var4_reg <= div_q;
        end
        if (cmd.save_msq)
        begin
            rad_rms_reg <= RAD_W'(var4_reg) + RAD_W'(mul_p[2*MEAN_W-1:2*FRAC_BITS-2]);
        end
        if (cmd.save_std)
        begin
            std_reg <= root_sat;
        end
        if (cmd.save_rms)
        begin
            rms_reg <= root_sat;
        end
        if (cmd.out_load)
        begin
            out_comp_reg      <= comp_reg;
            out_comp_mean_reg <= comp_mean_ns;
            out_total_reg     <= comp_count_reg;
            out_done_reg      <= sts.win_close;
            out_mean_reg      <= sts.win_close ? mean_ns[OUT_W-1:0] : '0;
            out_std_reg       <= sts.win_close ? std_reg : '0;
            out_rms_reg       <= sts.win_close ? rms_reg : '0;
            out_peak_reg      <= sts.win_close ? peak_reg : '0;
        end
    end

    always_comb
    begin
        sts.div_done  = div_done;
        sts.mul_done  = mul_done;
        sts.sqrt_done = sqrt_done;
        sts.opposite  = (d_reg[DIFF_W-1] && d2_pos) || (d_pos && d2[DIFF_W-1]);
        sts.win_close = win_count_reg >= eff_win;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign out_comp      = out_comp_reg;
    assign out_comp_mean = out_comp_mean_reg;
    assign out_total     = out_total_reg;
    assign out_done      = out_done_reg;
    assign out_mean      = out_mean_reg;
    assign out_std       = out_std_reg;
    assign out_rms       = out_rms_reg;
    assign out_peak      = out_peak_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |->
        (out_mean_reg == '0 && out_std_reg == '0 && out_rms_reg == '0 && out_peak_reg == '0))
        else $error("window fields nonzero without a closed window");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && sts.win_close) |=> (win_count_reg == '0 && m2_reg == '0))
        else $error("window state not cleared after close");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (win_count_reg != '0))
        else $error("window count not advanced on sample");

endmodule

// File: rtl/windowed_offset_jitter_stats.sv
`timescale 1ns / 1ps
// top level: windowed clock offset jitter statistics
//
// in_ch carries one signed offset sample (ns) per transfer; out_ch returns one
// result per sample: compensated offset, cumulative compensated mean, sample
// count and, on the sample that closes a window, the window mean, standard
// deviation, rms and peak absolute offset. cfg_ch writes the window length and
// is always ready; write it only while no sample is in flight.
// One sample at a time: the M2 multiply is skipped when the sample's deviations
// from the old and the updated mean differ in sign, and a sample that closes a
// window also computes the window statistics; the next sample can be taken in
// the cycle after the result is loaded. The work runs on the shared bit-serial
// divider (two runs, three on a window close), the partial product multiplier
// and the square root (two runs on close).
// The result sits in an output register, so the next sample is taken while a
// result waits; a stalled receiver holds the block only at the final load.
// Reset clears all statistics, sets the window length to 1000 and leaves the
// block idle and ready.
module windowed_offset_jitter_stats
(
    input  logic        clk,
    input  logic        rst_n,
    wojs_in_if.sink     in_ch,
    wojs_out_if.source  out_ch,
    wojs_cfg_if.sink    cfg_ch
);
    import wojs_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic    in_ready;

    assign in_ch.ready  = in_ready;
    assign cfg_ch.ready = 1'b1;

    wojs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wojs_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_offset     (in_ch.offset_ns),
        .cfg_we        (cfg_ch.valid),
        .cfg_data      (cfg_ch.window_samples),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .out_comp      (out_ch.comp_offset_ns),
        .out_comp_mean (out_ch.comp_mean_ns),
        .out_total     (out_ch.total_samples),
        .out_done      (out_ch.window_done),
        .out_mean      (out_ch.win_mean_ns),
        .out_std       (out_ch.win_stddev_ns),
        .out_rms       (out_ch.win_rms_ns),
        .out_peak      (out_ch.win_max_abs_ns)
    );

endmodule
